// ----- rtl/cpq_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// cpq_pkg - class priority queue shared definitions
// Action, status and register codes, threshold set type, class function and
// the struct handed along the row of queue cells.
// ============================================================================
package cpq_pkg;

    // Request actions
    localparam logic [1:0] ACT_ENQ = 2'd0;
    localparam logic [1:0] ACT_DEQ = 2'd1;
    localparam logic [1:0] ACT_REM = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_BADPOS = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_CHILD  = 2'd0;
    localparam logic [1:0] REG_YOUTH  = 2'd1;
    localparam logic [1:0] REG_SENIOR = 2'd2;
    localparam logic [1:0] REG_ELDER  = 2'd3;

    // Threshold reset values
    localparam logic [7:0] CHILD_RST  = 8'd5;
    localparam logic [7:0] YOUTH_RST  = 8'd16;
    localparam logic [7:0] SENIOR_RST = 8'd60;
    localparam logic [7:0] ELDER_RST  = 8'd80;

    typedef struct packed {
        logic [7:0] child;
        logic [7:0] youth;
        logic [7:0] senior;
        logic [7:0] elder;
    } limits_t;

    // Operation broadcast to every cell
    typedef struct packed {
        logic       do_insert;
        logic       do_take;
        logic [7:0] new_value;
        logic [1:0] new_class;
    } cell_ctl_t;

    // Signals handed from one cell to the next, head towards tail
    typedef struct packed {
        logic       ins_found;
        logic       take_hit;
        logic [7:0] take_value;
    } chain_t;

    // Priority class: 0 served first, 2 served last
    function automatic logic [1:0] class_of(input logic [7:0] v, input limits_t lim);
        logic [1:0] c;
        begin
            if ((v < lim.child) || (v > lim.elder))
                c = 2'd0;
            else if ((v < lim.youth) || (v > lim.senior))
                c = 2'd1;
            else
                c = 2'd2;
            return c;
        end
    endfunction

endpackage

// ----- rtl/cpq_ifs.sv -----
`timescale 1ns / 1ps
// ============================================================================
// cpq_ifs - class priority queue channel interfaces
// Request, result and configuration write channels, each with valid/ready.
// ============================================================================
interface cpq_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] item_value;
    logic [4:0] position;

    modport source (output valid, action, item_value, position, input ready);
    modport sink   (input valid, action, item_value, position, output ready);
endinterface

interface cpq_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] taken_value;
    logic [4:0] occupancy;

    modport source (output valid, status, taken_value, occupancy, input ready);
    modport sink   (input valid, status, taken_value, occupancy, output ready);
endinterface

interface cpq_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/class_priority_queue_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// class_priority_queue_top - bounded priority queue kept in class order
// A row of DEPTH cells holds the queue, head in cell 0. Enqueue, dequeue and
// remove-at-position each finish in the cycle the item is accepted.
// ============================================================================
//  channel | direction | payload
//  req     | in        | action, item_value, position
//  rsp     | out       | status, taken_value, occupancy
//  cfg     | in        | index, data (threshold registers)
//
//  One item per cycle while the result is drained: the cell row settles an
//  operation combinationally and the result is held in one output register.
//  req is ready while the output register is empty or being drained.
//  cfg is always ready and takes effect on the next item.
//  Reset empties the queue and loads the default thresholds; no sweep.
// ============================================================================
module class_priority_queue_top #(
    parameter int DEPTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    cpq_req_if.sink   req,
    cpq_rsp_if.source rsp,
    cpq_cfg_if.sink   cfg
);

    localparam int CNTW = $clog2(DEPTH + 1);
    localparam int IDXW = $clog2(DEPTH);
    localparam int PW   = (CNTW > 5) ? CNTW : 5;

    cpq_pkg::limits_t   limits_reg;
    cpq_pkg::cell_ctl_t ctl;
    cpq_pkg::chain_t    chain [DEPTH+1];

    logic [CNTW-1:0] count_reg;
    logic [CNTW-1:0] count_next;
    logic [IDXW-1:0] take_idx;
    logic [7:0]      cell_value [DEPTH];
    logic [PW-1:0]   pos_ext;
    logic [PW-1:0]   cnt_ext;
    logic [PW-1:0]   pos_m1;
    logic [PW-1:0]   occ_wide;
    logic            accept;
    logic            full;
    logic            empty;
    logic            pos_bad;
    logic [1:0]      status_c;

    logic            rsp_valid_reg;
    logic [1:0]      status_reg;
    logic [7:0]      taken_reg;
    logic [4:0]      occ_reg;

    // Handshakes
    assign accept    = req.valid && req.ready;
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign cfg.ready = 1'b1;

    // Threshold registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.child  <= cpq_pkg::CHILD_RST;
            limits_reg.youth  <= cpq_pkg::YOUTH_RST;
            limits_reg.senior <= cpq_pkg::SENIOR_RST;
            limits_reg.elder  <= cpq_pkg::ELDER_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                cpq_pkg::REG_CHILD:  limits_reg.child  <= cfg.data;
                cpq_pkg::REG_YOUTH:  limits_reg.youth  <= cfg.data;
                cpq_pkg::REG_SENIOR: limits_reg.senior <= cfg.data;
                cpq_pkg::REG_ELDER:  limits_reg.elder  <= cfg.data;
                default: ;
            endcase
        end
    end

    // Decode the request
    assign full    = (count_reg == CNTW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pos_ext = PW'(req.position);
    assign cnt_ext = PW'(count_reg);
    assign pos_m1  = pos_ext - PW'(1);
    assign pos_bad = (pos_ext == '0) || (pos_ext > cnt_ext);

    always_comb
    begin
        status_c      = cpq_pkg::ST_OK;
        ctl.do_insert = 1'b0;
        ctl.do_take   = 1'b0;
        ctl.new_value = req.item_value;
        ctl.new_class = cpq_pkg::class_of(req.item_value, limits_reg);
        take_idx      = '0;
        case (req.action)
            cpq_pkg::ACT_ENQ:
            begin
                if (full)
                    status_c = cpq_pkg::ST_FULL;
                else
                    ctl.do_insert = accept;
            end
            cpq_pkg::ACT_DEQ:
            begin
                if (empty)
                    status_c = cpq_pkg::ST_EMPTY;
                else
                    ctl.do_take = accept;
            end
            cpq_pkg::ACT_REM:
            begin
                if (empty)
                    status_c = cpq_pkg::ST_EMPTY;
                else if (pos_bad)
                    status_c = cpq_pkg::ST_BADPOS;
                else
                begin
                    ctl.do_take = accept;
                    take_idx    = pos_m1[IDXW-1:0];
                end
            end
            default: ;
        endcase
    end

    // Row of cells, head first
    assign chain[0] = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [7:0] prev_v;
        logic [7:0] next_v;

        if (i == 0)
        begin : g_head
            assign prev_v = req.item_value;
        end
        else
        begin : g_body
            assign prev_v = cell_value[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign next_v = cell_value[i];
        end
        else
        begin : g_inner
            assign next_v = cell_value[i+1];
        end

        cpq_cell u_cell (
            .clk        (clk),
            .limits     (limits_reg),
            .ctl        (ctl),
            .slot_valid (CNTW'(i) < count_reg),
            .at_tail    (CNTW'(i) == count_reg),
            .at_take    (IDXW'(i) == take_idx),
            .prev_value (prev_v),
            .next_value (next_v),
            .chain_in   (chain[i]),
            .chain_out  (chain[i+1]),
            .value      (cell_value[i])
        );
    end

    // Entry count
    always_comb
    begin
        count_next = count_reg;
        if (ctl.do_insert)
            count_next = count_reg + CNTW'(1);
        else if (ctl.do_take)
            count_next = count_reg - CNTW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // Result register
    assign occ_wide = PW'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (accept)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_c;
            taken_reg  <= ctl.do_take ? chain[DEPTH].take_value : 8'd0;
            occ_reg    <= occ_wide[4:0];
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.taken_value = taken_reg;
    assign rsp.occupancy   = occ_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTW'(DEPTH))
        else $error("entry count above depth");

    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.do_insert && ctl.do_take))
        else $error("insert and take together");

    a_take_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.do_take |-> (CNTW'(take_idx) < count_reg))
        else $error("take beyond last entry");

    a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.action == cpq_pkg::ACT_ENQ) && !full)
        |=> (count_reg == $past(count_reg) + CNTW'(1)))
        else $error("enqueue did not add an entry");

    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.action == cpq_pkg::ACT_ENQ) && full)
        |=> (count_reg == $past(count_reg)))
        else $error("rejected enqueue changed the count");
`endif

endmodule

// ----- rtl/cpq_cell.sv -----
`timescale 1ns / 1ps
// ============================================================================
// cpq_cell - one slot of the class priority queue
// Holds one entry, works out its class against the live thresholds and
// shifts towards the tail on insert or towards the head on take.
// ============================================================================
module cpq_cell (
    input  logic              clk,
    input  cpq_pkg::limits_t  limits,
    input  cpq_pkg::cell_ctl_t ctl,
    input  logic              slot_valid,
    input  logic              at_tail,
    input  logic              at_take,
    input  logic [7:0]        prev_value,
    input  logic [7:0]        next_value,
    input  cpq_pkg::chain_t   chain_in,
    output cpq_pkg::chain_t   chain_out,
    output logic [7:0]        value
);

    logic [7:0] value_reg;
    logic [7:0] value_next;
    logic [1:0] own_class;
    logic       worse;
    logic       take_here;

    // Compare own class with the incoming one
    assign own_class = cpq_pkg::class_of(value_reg, limits);
    assign worse     = slot_valid && (own_class > ctl.new_class);
    assign take_here = chain_in.take_hit || at_take;

    // Pass insert and take state on to the next cell
    assign chain_out.ins_found  = chain_in.ins_found || worse || at_tail;
    assign chain_out.take_hit   = take_here;
    assign chain_out.take_value = at_take ? value_reg : chain_in.take_value;

    // Select the next entry value
    always_comb
    begin
        value_next = value_reg;
        if (ctl.do_insert)
        begin
            if (chain_in.ins_found)
                value_next = prev_value;
            else if (worse || at_tail)
                value_next = ctl.new_value;
        end
        else if (ctl.do_take && take_here)
        begin
            value_next = next_value;
        end
    end

    // Hold the entry
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ----- tb/sv/class_priority_queue_top_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// class_priority_queue_top_tb - regression bench for the class priority queue
// Drives enqueue, dequeue and remove requests under several threshold sets
// and predicts each result with a local copy of the queue and thresholds.
// Every result is compared field by field with the oldest prediction.
// Both channels idle at random, apart from one long unstalled stretch.
// ============================================================================
module class_priority_queue_top_tb;

    localparam int         QDEPTH   = 16;
    localparam logic [1:0] ACT_NOP  = 2'd3;
    localparam int         IDLE_PCT = 27;
    localparam int         MAX_REPORTS = 10;

    // Predicted result of one request
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] taken;
        logic [4:0] occupancy;
    } outcome_t;

    logic clk;
    logic rst_n;

    cpq_req_if req_ch ();
    cpq_rsp_if rsp_ch ();
    cpq_cfg_if cfg_ch ();

    class_priority_queue_top #(.DEPTH(QDEPTH)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Local copy of the queue and the thresholds
    logic [7:0]        slots [QDEPTH];
    int unsigned       fill;
    cpq_pkg::limits_t  thresholds;

    outcome_t expected_outcomes [$];

    bit stall_on;
    int items_sent;
    int results_checked;
    int mismatches;
    int fail_count;
    int full_seen;
    int empty_seen;
    int badpos_seen;

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Limit on the whole run
    initial
    begin
        #2_000_000;
        $display("timeout with %0d results outstanding", expected_outcomes.size());
        $display("class_priority_queue_top regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    function automatic int unsigned rank_of(input logic [7:0] v);
        if ((v < thresholds.child) || (v > thresholds.elder))
            return 0;
        if ((v < thresholds.youth) || (v > thresholds.senior))
            return 1;
        return 2;
    endfunction

    // Take out the slot at 0-based index k and close the gap
    function automatic logic [7:0] take_slot(input int unsigned k);
        logic [7:0]  v;
        int unsigned i;
        v = slots[k];
        for (i = k; i + 1 < fill; i++)
            slots[i] = slots[i + 1];
        slots[fill - 1] = 8'd0;
        fill--;
        return v;
    endfunction

    function automatic outcome_t apply_op(input logic [1:0] act, input logic [7:0] val,
                                          input logic [4:0] pos);
        outcome_t    o;
        int unsigned c;
        int unsigned k;
        int unsigned i;
        o = '0;
        o.status = cpq_pkg::ST_OK;
        case (act)
            cpq_pkg::ACT_ENQ:
            begin
                if (fill >= QDEPTH)
                    o.status = cpq_pkg::ST_FULL;
                else
                begin
                    c = rank_of(val);
                    k = 0;
                    while ((k < fill) && (c >= rank_of(slots[k])))
                        k++;
                    for (i = fill; i > k; i--)
                        slots[i] = slots[i - 1];
                    slots[k] = val;
                    fill++;
                end
            end
            cpq_pkg::ACT_DEQ:
            begin
                if (fill == 0)
                    o.status = cpq_pkg::ST_EMPTY;
                else
                    o.taken = take_slot(0);
            end
            cpq_pkg::ACT_REM:
            begin
                if (fill == 0)
                    o.status = cpq_pkg::ST_EMPTY;
                else if ((pos == 5'd0) || (pos > fill))
                    o.status = cpq_pkg::ST_BADPOS;
                else
                    o.taken = take_slot(pos - 1);
            end
            default: ;
        endcase
        o.occupancy = fill[4:0];
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking, with random back-pressure on the result channel
    // ------------------------------------------------------------------------
    initial
    begin
        outcome_t want;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    mismatches++;
                    fail_count++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result: status %0d taken %0d occupancy %0d",
                                 rsp_ch.status, rsp_ch.taken_value, rsp_ch.occupancy);
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    results_checked++;
                    case (want.status)
                        cpq_pkg::ST_FULL:   full_seen++;
                        cpq_pkg::ST_EMPTY:  empty_seen++;
                        cpq_pkg::ST_BADPOS: badpos_seen++;
                        default: ;
                    endcase
                    if ((rsp_ch.status !== want.status) ||
                        (rsp_ch.taken_value !== want.taken) ||
                        (rsp_ch.occupancy !== want.occupancy))
                    begin
                        mismatches++;
                        fail_count++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"result %0d: expected st %0d val %0d occ %0d,",
                                      " got st %0d val %0d occ %0d"},
                                     results_checked, want.status, want.taken,
                                     want.occupancy, rsp_ch.status, rsp_ch.taken_value,
                                     rsp_ch.occupancy);
                    end
                end
            end
            if (stall_on && ($urandom_range(99) < IDLE_PCT))
                rsp_ch.ready <= 1'b0;
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------------

    // Send one request item; valid stays high for a following item
    task automatic send_op(input logic [1:0] act, input logic [7:0] val,
                           input logic [4:0] pos);
        while (stall_on && ($urandom_range(99) < IDLE_PCT))
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.action     <= act;
        req_ch.item_value <= val;
        req_ch.position   <= pos;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        expected_outcomes.push_back(apply_op(act, val, pos));
        items_sent++;
    endtask

    // Drop the request valid and hold until every result is back
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (expected_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // Write all four thresholds while the queue is idle
    task automatic set_limits(input logic [7:0] child, input logic [7:0] youth,
                              input logic [7:0] senior, input logic [7:0] elder);
        logic [7:0] vals [4];
        int         r;
        vals[cpq_pkg::REG_CHILD]  = child;
        vals[cpq_pkg::REG_YOUTH]  = youth;
        vals[cpq_pkg::REG_SENIOR] = senior;
        vals[cpq_pkg::REG_ELDER]  = elder;
        wait_drained();
        for (r = 0; r < 4; r++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= r[1:0];
            cfg_ch.data  <= vals[r];
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
        end
        cfg_ch.valid      <= 1'b0;
        thresholds.child  = child;
        thresholds.youth  = youth;
        thresholds.senior = senior;
        thresholds.elder  = elder;
    endtask

    // Random value, often at or beside a threshold edge
    function automatic logic [7:0] pick_value();
        logic [7:0] edge_v;
        case ($urandom_range(3))
            0: edge_v = thresholds.child;
            1: edge_v = thresholds.elder;
            2: edge_v = ($urandom_range(1) != 0) ? thresholds.youth : thresholds.senior;
            default: return 8'($urandom_range(255));
        endcase
        if ($urandom_range(1) != 0)
            return 8'($urandom_range(255));
        return edge_v + 8'($urandom_range(2)) - 8'd1;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Empty cases, every class and boundary, bad positions, no-op
    task automatic test_directed_cases();
        send_op(cpq_pkg::ACT_DEQ, 8'd0,   5'd0);
        send_op(cpq_pkg::ACT_REM, 8'd0,   5'd1);
        send_op(cpq_pkg::ACT_ENQ, 8'd30,  5'd0);
        send_op(cpq_pkg::ACT_ENQ, 8'd10,  5'd0);
        send_op(cpq_pkg::ACT_ENQ, 8'd0,   5'd0);
        send_op(cpq_pkg::ACT_ENQ, 8'd255, 5'd31);
        send_op(cpq_pkg::ACT_ENQ, 8'd70,  5'd0);
        send_op(cpq_pkg::ACT_ENQ, 8'd4,   5'd0);
        send_op(cpq_pkg::ACT_ENQ, 8'd5,   5'd0);
        send_op(cpq_pkg::ACT_ENQ, 8'd16,  5'd0);
        send_op(cpq_pkg::ACT_ENQ, 8'd60,  5'd0);
        send_op(cpq_pkg::ACT_ENQ, 8'd61,  5'd0);
        send_op(cpq_pkg::ACT_ENQ, 8'd80,  5'd0);
        send_op(cpq_pkg::ACT_ENQ, 8'd81,  5'd0);
        send_op(ACT_NOP,          8'd255, 5'd31);
        send_op(cpq_pkg::ACT_REM, 8'd255, 5'd0);
        send_op(cpq_pkg::ACT_REM, 8'd0,   5'd31);
        send_op(cpq_pkg::ACT_REM, 8'd0,   5'd13);
        send_op(cpq_pkg::ACT_REM, 8'd0,   5'd12);
        send_op(cpq_pkg::ACT_REM, 8'd0,   5'd1);
        send_op(cpq_pkg::ACT_REM, 8'd0,   5'd5);
        send_op(cpq_pkg::ACT_DEQ, 8'd0,   5'd0);
    endtask

    // Fill to the top, push past full, then drain to empty and beyond
    task automatic test_full_and_drain();
        int n;
        while (fill < QDEPTH)
            send_op(cpq_pkg::ACT_ENQ, pick_value(), 5'($urandom_range(31)));
        for (n = 0; n < 3; n++)
            send_op(cpq_pkg::ACT_ENQ, pick_value(), 5'($urandom_range(31)));
        while (fill > 0)
        begin
            if ($urandom_range(1) != 0)
                send_op(cpq_pkg::ACT_DEQ, pick_value(), 5'($urandom_range(31)));
            else
                send_op(cpq_pkg::ACT_REM, pick_value(), 5'($urandom_range(fill, 1)));
        end
        send_op(cpq_pkg::ACT_DEQ, pick_value(), 5'($urandom_range(31)));
    endtask

    // Mixed traffic, alternating fill-heavy and drain-heavy stretches
    task automatic test_random_traffic(input int n_ops);
        int         i;
        int         enq_pct;
        int         r;
        logic [1:0] act;
        logic [4:0] pos;
        for (i = 0; i < n_ops; i++)
        begin
            enq_pct = (((i / 32) % 2) == 0) ? 75 : 30;
            r = $urandom_range(99);
            if (r < enq_pct)
                act = cpq_pkg::ACT_ENQ;
            else
            begin
                r = $urandom_range(9);
                act = (r < 4) ? cpq_pkg::ACT_DEQ :
                      ((r < 9) ? cpq_pkg::ACT_REM : ACT_NOP);
            end
            if ((fill > 0) && ($urandom_range(4) != 0))
                pos = 5'($urandom_range(fill, 1));
            else
                pos = 5'($urandom_range(31));
            send_op(act, pick_value(), pos);
        end
    endtask

    // Same traffic with no idling on either side
    task automatic test_unstalled_burst(input int n_ops);
        stall_on = 1'b0;
        test_random_traffic(n_ops);
        wait_drained();
        stall_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int drain_cycles;
        clk               = 1'b0;
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.action     = cpq_pkg::ACT_ENQ;
        req_ch.item_value = 8'd0;
        req_ch.position   = 5'd0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = cpq_pkg::REG_CHILD;
        cfg_ch.data       = 8'd0;
        stall_on          = 1'b1;
        fill              = 0;
        for (int s = 0; s < QDEPTH; s++)
            slots[s] = 8'd0;
        thresholds.child  = cpq_pkg::CHILD_RST;
        thresholds.youth  = cpq_pkg::YOUTH_RST;
        thresholds.senior = cpq_pkg::SENIOR_RST;
        thresholds.elder  = cpq_pkg::ELDER_RST;

        // Hold reset, then release it
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_full_and_drain();

        set_limits(8'd0, 8'd0, 8'd0, 8'd0);
        test_random_traffic(320);

        set_limits(8'd255, 8'd255, 8'd255, 8'd255);
        test_random_traffic(320);

        set_limits(8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'($urandom_range(255)));
        test_unstalled_burst(320);

        set_limits(8'd255, 8'd0, 8'd255, 8'd0);
        test_random_traffic(320);

        set_limits(cpq_pkg::CHILD_RST, cpq_pkg::YOUTH_RST,
                   cpq_pkg::SENIOR_RST, cpq_pkg::ELDER_RST);
        test_random_traffic(320);

        // Wait for the last results, then let the bench idle before the report
        req_ch.valid <= 1'b0;
        drain_cycles = 0;
        while ((expected_outcomes.size() != 0) && (drain_cycles < 20000))
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (5) @(posedge clk);
        if (expected_outcomes.size() != 0)
        begin
            fail_count++;
            $display("%0d results never arrived", expected_outcomes.size());
        end

        $display("%0d requests sent over six threshold sets, %0d results compared",
                 items_sent, results_checked);
        $display("%0d mismatched; rejections seen: %0d full, %0d empty, %0d bad position",
                 mismatches, full_seen, empty_seen, badpos_seen);
        if (fail_count == 0)
            $display("class_priority_queue_top regression: pass");
        else
            $display("class_priority_queue_top regression: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/cpq_pkg.sv
rtl/cpq_ifs.sv
rtl/cpq_cell.sv
rtl/class_priority_queue_top.sv
tb/sv/class_priority_queue_top_tb.sv
